[src/segment_box_slab_clipper_defines.svh]
// Assertion macros shared by the segment box slab clipper RTL.
`ifndef SEGMENT_BOX_SLAB_CLIPPER_DEFINES_SVH
`define SEGMENT_BOX_SLAB_CLIPPER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SCB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/scb_pkg.sv]
// Shared constants, register codes and stage payload types of the slab clipper.
package scb_pkg;

  localparam int COORD_W   = 32;
  localparam int MARGIN_W  = 31;
  localparam int CFG_IDX_W = 3;
  localparam int T_FRAC    = 24;
  localparam int TQ_W      = T_FRAC + 1;
  localparam logic [TQ_W-1:0] TQ_ONE = TQ_W'(1) << T_FRAC;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X,
    REG_MAX_X,
    REG_MIN_Y,
    REG_MAX_Y,
    REG_MIN_Z,
    REG_MAX_Z,
    REG_MARGIN
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] lo_face;
    logic [2:0][COORD_W-1:0] hi_face;
    logic [MARGIN_W-1:0]     margin;
  } box_cfg_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] start_pt;
    logic [2:0][COORD_W-1:0] end_pt;
  } seg_t;

  // unsigned fraction num/den, num <= den whenever the item survives (ok)
  typedef struct packed {
    logic [COORD_W-1:0] num;
    logic [COORD_W-1:0] den;
  } frac_t;

  // per-axis data needed for the final point evaluation
  typedef struct packed {
    logic [COORD_W-1:0] s;
    logic               neg;
    logic [COORD_W-1:0] mag;
  } axis_geo_t;

  typedef axis_geo_t [2:0] seg_geo_t;

  // setup stage one: shrunk faces and direction
  typedef struct packed {
    logic [2:0][COORD_W:0]   lo;
    logic [2:0][COORD_W:0]   hi;
    logic [2:0][COORD_W:0]   d;
    logic [2:0][COORD_W-1:0] s;
  } s1_t;

  // setup stage two: slab distances along the direction
  typedef struct packed {
    logic                      bad;
    logic [2:0]                neg;
    logic [2:0]                zero;
    logic [2:0]                zin;
    logic [2:0][COORD_W-1:0]   den;
    logic [2:0][COORD_W-1:0]   s;
    logic [2:0][COORD_W+1:0]   a;
    logic [2:0][COORD_W+1:0]   b;
  } s2_t;

  // per-axis entry and exit fractions
  typedef struct packed {
    logic             ok;
    frac_t [2:0]      ent;
    frac_t [2:0]      ext;
    seg_geo_t         geo;
  } ival_t;

  // merged interval
  typedef struct packed {
    logic     ok;
    frac_t    en;
    frac_t    ex;
    seg_geo_t geo;
  } span_t;

  // divider stage state for both interval ends
  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] er;
    logic [COORD_W-1:0] ed;
    logic [TQ_W-1:0]    eq;
    logic [COORD_W-1:0] xr;
    logic [COORD_W-1:0] xd;
    logic [TQ_W-1:0]    xq;
    seg_geo_t           geo;
  } div_st_t;

  typedef struct packed {
    logic            ok;
    logic [TQ_W-1:0] t0;
    logic [TQ_W-1:0] t1;
    seg_geo_t        geo;
  } tpar_t;

  typedef struct packed {
    logic                    ok;
    logic [2:0][COORD_W-1:0] p0;
    logic [2:0][COORD_W-1:0] p1;
  } clip_t;

endpackage

[src/scb_seg_if.sv]
// Segment input channel: valid/ready handshake with start and end coordinates.
interface scb_seg_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_x;
  logic [31:0] start_y;
  logic [31:0] start_z;
  logic [31:0] end_x;
  logic [31:0] end_y;
  logic [31:0] end_z;

  modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 input ready);
  modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z,
               output ready);
endinterface

[src/scb_clip_if.sv]
// Clip result channel: valid/ready handshake with the clipped segment.
interface scb_clip_if;
  logic        valid;
  logic        ready;
  logic        clip_valid;
  logic [31:0] clip_start_x;
  logic [31:0] clip_start_y;
  logic [31:0] clip_start_z;
  logic [31:0] clip_end_x;
  logic [31:0] clip_end_y;
  logic [31:0] clip_end_z;

  modport source(output valid, clip_valid, clip_start_x, clip_start_y, clip_start_z,
                 clip_end_x, clip_end_y, clip_end_z, input ready);
  modport sink(input valid, clip_valid, clip_start_x, clip_start_y, clip_start_z,
               clip_end_x, clip_end_y, clip_end_z, output ready);
endinterface

[src/segment_box_slab_clipper.sv]
// Top level of the segment box slab clipper: config registers and pipeline chain.
//
// Clips one 3D segment per item against an axis-aligned box shrunk inward by
// a margin on every face. Coordinates are signed Q20.12.
// Channels: in_ch (sink) takes start_x/y/z and end_x/y/z; out_ch (source)
// gives clip_valid and the clipped start and end points, zero when invalid.
// Both use valid/ready; an item moves when both are high.
// Configuration: cfg_we writes cfg_wdata to the register cfg_index selects
// (box faces, then margin); indexes past the margin are ignored. Write only
// while no item is in flight.
// Pipeline from acceptance to the result on out_ch: 3 setup
// stages, 6 interval merge stages, 25 divider stages (one quotient bit of t
// each) and 2 point stages. Throughput: one item per cycle while out_ch takes them.
// Reset clears the configuration registers to zero and empties the pipeline.
// When out_ch stalls, items keep entering until every stage holds one; each
// stage carries its own valid bit, so empty stages fill while the output
// waits, and in_ch.ready drops only when the whole pipe is full.
`include "segment_box_slab_clipper_defines.svh"
module segment_box_slab_clipper import scb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  scb_seg_if.sink              in_ch,
  scb_clip_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  logic [2:0][COORD_W-1:0] lo_face_r, hi_face_r;
  logic [MARGIN_W-1:0]     margin_r;
  box_cfg_t box_cfg;
  seg_t     seg;

  logic  su_valid, su_ready;
  ival_t su_ival;
  logic  iv_valid, iv_ready;
  span_t iv_span;
  logic  dv_valid, dv_ready;
  tpar_t dv_tpar;
  clip_t clip;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_face_r <= '0;
      hi_face_r <= '0;
      margin_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X:  lo_face_r[0] <= cfg_wdata;
        REG_MAX_X:  hi_face_r[0] <= cfg_wdata;
        REG_MIN_Y:  lo_face_r[1] <= cfg_wdata;
        REG_MAX_Y:  hi_face_r[1] <= cfg_wdata;
        REG_MIN_Z:  lo_face_r[2] <= cfg_wdata;
        REG_MAX_Z:  hi_face_r[2] <= cfg_wdata;
        REG_MARGIN: margin_r     <= cfg_wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign box_cfg.lo_face = lo_face_r;
  assign box_cfg.hi_face = hi_face_r;
  assign box_cfg.margin  = margin_r;

  assign seg.start_pt[0] = in_ch.start_x;
  assign seg.start_pt[1] = in_ch.start_y;
  assign seg.start_pt[2] = in_ch.start_z;
  assign seg.end_pt[0]   = in_ch.end_x;
  assign seg.end_pt[1]   = in_ch.end_y;
  assign seg.end_pt[2]   = in_ch.end_z;

  scb_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .box_cfg   (box_cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_seg    (seg),
    .out_valid (su_valid),
    .out_ready (su_ready),
    .out_ival  (su_ival)
  );

  scb_interval u_interval (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (su_valid),
    .in_ready  (su_ready),
    .in_ival   (su_ival),
    .out_valid (iv_valid),
    .out_ready (iv_ready),
    .out_span  (iv_span)
  );

  scb_tdiv u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (iv_valid),
    .in_ready  (iv_ready),
    .in_span   (iv_span),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_tpar  (dv_tpar)
  );

  scb_point u_point (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_tpar   (dv_tpar),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_clip  (clip)
  );

  assign out_ch.clip_valid   = clip.ok;
  assign out_ch.clip_start_x = clip.p0[0];
  assign out_ch.clip_start_y = clip.p0[1];
  assign out_ch.clip_start_z = clip.p0[2];
  assign out_ch.clip_end_x   = clip.p1[0];
  assign out_ch.clip_end_y   = clip.p1[1];
  assign out_ch.clip_end_z   = clip.p1[2];

  `SCB_ASSERT_NXT(a_margin_write, clk, rst_n, cfg_we && (cfg_index == REG_MARGIN),
    margin_r == $past(cfg_wdata[MARGIN_W-1:0]), "margin write lost")
  `SCB_ASSERT_NXT(a_min_x_write, clk, rst_n, cfg_we && (cfg_index == REG_MIN_X),
    lo_face_r[0] == $past(cfg_wdata), "min x write lost")
  `SCB_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_ch.valid && !out_ch.clip_valid,
    (clip.p0 == '0) && (clip.p1 == '0), "invalid result with nonzero points")

endmodule

[src/scb_setup.sv]
// Setup pipeline: shrunk box, direction, slab distances and per-axis fractions.
module scb_setup import scb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  box_cfg_t box_cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  seg_t     in_seg,
  output logic     out_valid,
  input  logic     out_ready,
  output ival_t    out_ival
);

  localparam int NS = 3;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  ival_t s3_r, s3_nxt;
  logic [2:0][COORD_W+1:0] ap, bp;
  logic [2:0] ok_ax;

  // ready ripples back through empty stages
  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_ival  = s3_r;

  // stage 1: shrink faces, direction
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_nxt.lo[k] = $signed({box_cfg.lo_face[k][COORD_W-1], box_cfg.lo_face[k]})
                   + $signed({2'b00, box_cfg.margin});
      s1_nxt.hi[k] = $signed({box_cfg.hi_face[k][COORD_W-1], box_cfg.hi_face[k]})
                   - $signed({2'b00, box_cfg.margin});
      s1_nxt.d[k]  = $signed({in_seg.end_pt[k][COORD_W-1], in_seg.end_pt[k]})
                   - $signed({in_seg.start_pt[k][COORD_W-1], in_seg.start_pt[k]});
      s1_nxt.s[k]  = in_seg.start_pt[k];
    end
  end

  // stage 2: distances to both faces measured along the direction
  always_comb begin
    s2_nxt.bad = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ap[k] = $signed({s1_r.lo[k][COORD_W], s1_r.lo[k]})
            - $signed({{2{s1_r.s[k][COORD_W-1]}}, s1_r.s[k]});
      bp[k] = $signed({s1_r.hi[k][COORD_W], s1_r.hi[k]})
            - $signed({{2{s1_r.s[k][COORD_W-1]}}, s1_r.s[k]});
      if ($signed(s1_r.lo[k]) > $signed(s1_r.hi[k])) begin
        s2_nxt.bad = 1'b1;
      end
      s2_nxt.neg[k]  = s1_r.d[k][COORD_W];
      s2_nxt.zero[k] = (s1_r.d[k] == '0);
      // start inside slab: lo - s <= 0 and hi - s >= 0
      s2_nxt.zin[k]  = (ap[k][COORD_W+1] || (ap[k] == '0)) && !bp[k][COORD_W+1];
      s2_nxt.den[k]  = s1_r.d[k][COORD_W] ? COORD_W'(-s1_r.d[k])
                                          : s1_r.d[k][COORD_W-1:0];
      s2_nxt.s[k]    = s1_r.s[k];
      s2_nxt.a[k]    = s1_r.d[k][COORD_W] ? -bp[k] : ap[k];
      s2_nxt.b[k]    = s1_r.d[k][COORD_W] ? -ap[k] : bp[k];
    end
  end

  // stage 3: clamp to [0, den] and form fractions
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s3_nxt.geo[k].s   = s2_r.s[k];
      s3_nxt.geo[k].neg = s2_r.neg[k];
      s3_nxt.geo[k].mag = s2_r.den[k];
      if (s2_r.zero[k]) begin
        ok_ax[k]          = s2_r.zin[k];
        s3_nxt.ent[k].num = '0;
        s3_nxt.ent[k].den = COORD_W'(1);
        s3_nxt.ext[k].num = COORD_W'(1);
        s3_nxt.ext[k].den = COORD_W'(1);
      end else begin
        ok_ax[k] = !s2_r.b[k][COORD_W+1]
                && !($signed(s2_r.a[k]) > $signed({2'b00, s2_r.den[k]}));
        s3_nxt.ent[k].num = s2_r.a[k][COORD_W+1] ? '0 : s2_r.a[k][COORD_W-1:0];
        s3_nxt.ent[k].den = s2_r.den[k];
        s3_nxt.ext[k].num = ($signed(s2_r.b[k]) > $signed({2'b00, s2_r.den[k]}))
                          ? s2_r.den[k] : s2_r.b[k][COORD_W-1:0];
        s3_nxt.ext[k].den = s2_r.den[k];
      end
    end
    s3_nxt.ok = !s2_r.bad && (&ok_ax);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) s1_r <= s1_nxt;
    if (rdy[1]) s2_r <= s2_nxt;
    if (rdy[2]) s3_r <= s3_nxt;
  end

endmodule

[src/scb_interval.sv]
// Interval pipeline: merges the three slab intervals by cross multiplication.
module scb_interval import scb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  ival_t in_ival,
  output logic  out_valid,
  input  logic  out_ready,
  output span_t out_span
);

  localparam int NS = 6;
  localparam int PW = 2 * COORD_W;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  // stage 1: x against y products
  ival_t          i1_r;
  logic [PW-1:0]  pe1_r, pe2_r, px1_r, px2_r;
  // stage 2: x/y merged, z carried
  span_t          i2_r, i2_nxt;
  frac_t          ez2_r, xz2_r;
  // stage 3: merged against z products
  span_t          i3_r;
  frac_t          ez3_r, xz3_r;
  logic [PW-1:0]  qe1_r, qe2_r, qx1_r, qx2_r;
  // stage 4: all axes merged
  span_t          i4_r, i4_nxt;
  // stage 5: emptiness products
  span_t          i5_r;
  logic [PW-1:0]  pf1_r, pf2_r;
  // stage 6: final check
  span_t          i6_r, i6_nxt;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_span  = i6_r;

  // keep the larger entry and the smaller exit; ties keep the earlier axis
  always_comb begin
    i2_nxt.ok  = i1_r.ok;
    i2_nxt.geo = i1_r.geo;
    i2_nxt.en  = (pe2_r > pe1_r) ? i1_r.ent[1] : i1_r.ent[0];
    i2_nxt.ex  = (px2_r < px1_r) ? i1_r.ext[1] : i1_r.ext[0];
  end

  always_comb begin
    i4_nxt    = i3_r;
    i4_nxt.en = (qe2_r > qe1_r) ? ez3_r : i3_r.en;
    i4_nxt.ex = (qx2_r < qx1_r) ? xz3_r : i3_r.ex;
  end

  always_comb begin
    i6_nxt    = i5_r;
    i6_nxt.ok = i5_r.ok && (pf1_r <= pf2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      i1_r  <= in_ival;
      pe1_r <= in_ival.ent[0].num * in_ival.ent[1].den;
      pe2_r <= in_ival.ent[1].num * in_ival.ent[0].den;
      px1_r <= in_ival.ext[0].num * in_ival.ext[1].den;
      px2_r <= in_ival.ext[1].num * in_ival.ext[0].den;
    end
    if (rdy[1]) begin
      i2_r  <= i2_nxt;
      ez2_r <= i1_r.ent[2];
      xz2_r <= i1_r.ext[2];
    end
    if (rdy[2]) begin
      i3_r  <= i2_r;
      ez3_r <= ez2_r;
      xz3_r <= xz2_r;
      qe1_r <= i2_r.en.num * ez2_r.den;
      qe2_r <= ez2_r.num * i2_r.en.den;
      qx1_r <= i2_r.ex.num * xz2_r.den;
      qx2_r <= xz2_r.num * i2_r.ex.den;
    end
    if (rdy[3]) i4_r <= i4_nxt;
    if (rdy[4]) begin
      i5_r  <= i4_r;
      pf1_r <= i4_r.en.num * i4_r.ex.den;
      pf2_r <= i4_r.ex.num * i4_r.en.den;
    end
    if (rdy[5]) i6_r <= i6_nxt;
  end

endmodule

[src/scb_tdiv.sv]
// Restoring divider pipeline: one quotient bit per stage for both interval ends.
`include "segment_box_slab_clipper_defines.svh"
module scb_tdiv import scb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  span_t in_span,
  output logic  out_valid,
  input  logic  out_ready,
  output tpar_t out_tpar
);

  localparam int NS = TQ_W;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  div_st_t       st_r [NS];
  div_st_t       first_st;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_tpar.ok  = st_r[NS-1].ok;
  assign out_tpar.t0  = st_r[NS-1].eq;
  assign out_tpar.t1  = st_r[NS-1].xq;
  assign out_tpar.geo = st_r[NS-1].geo;

  // partial remainders start at the numerators
  always_comb begin
    first_st.ok  = in_span.ok;
    first_st.er  = in_span.en.num;
    first_st.ed  = in_span.en.den;
    first_st.eq  = '0;
    first_st.xr  = in_span.ex.num;
    first_st.xd  = in_span.ex.den;
    first_st.xq  = '0;
    first_st.geo = in_span.geo;
  end

  for (genvar j = 0; j < NS; j++) begin : g_st
    div_st_t          src, nxt;
    logic [COORD_W:0] esh, xsh, esub, xsub;
    logic             ege, xge;

    if (j == 0) begin : g_head
      assign src = first_st;
      // numerator <= divisor for ok items: the integer bit needs no shift
      assign esh = {1'b0, src.er};
      assign xsh = {1'b0, src.xr};
    end else begin : g_body
      assign src = st_r[j-1];
      assign esh = {src.er, 1'b0};
      assign xsh = {src.xr, 1'b0};
    end

    // compare and restore
    always_comb begin
      esub    = esh - {1'b0, src.ed};
      xsub    = xsh - {1'b0, src.xd};
      ege     = esh >= {1'b0, src.ed};
      xge     = xsh >= {1'b0, src.xd};
      nxt     = src;
      nxt.er  = ege ? esub[COORD_W-1:0] : esh[COORD_W-1:0];
      nxt.xr  = xge ? xsub[COORD_W-1:0] : xsh[COORD_W-1:0];
      nxt.eq  = {src.eq[TQ_W-2:0], ege};
      nxt.xq  = {src.xq[TQ_W-2:0], xge};
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) st_r[j] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  `SCB_ASSERT_IMP(a_rem_below_div, clk, rst_n, v_r[NS-1] && st_r[NS-1].ok,
    st_r[NS-1].er < st_r[NS-1].ed, "remainder not below divisor")
  `SCB_ASSERT_IMP(a_t_in_range, clk, rst_n, v_r[NS-1] && st_r[NS-1].ok,
    (st_r[NS-1].eq <= TQ_ONE) && (st_r[NS-1].xq <= TQ_ONE), "t above one")
  `SCB_ASSERT_IMP(a_t_ordered, clk, rst_n, v_r[NS-1] && st_r[NS-1].ok,
    st_r[NS-1].eq <= st_r[NS-1].xq, "entry t past exit t")

endmodule

[src/scb_point.sv]
// Point pipeline: scales the direction by t and offsets from the start point.
module scb_point import scb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  tpar_t in_tpar,
  output logic  out_valid,
  input  logic  out_ready,
  output clip_t out_clip
);

  localparam int NS = 2;
  localparam int PW = TQ_W + COORD_W;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  logic                    ok1_r;
  logic [2:0][COORD_W-1:0] s1_r;
  logic [2:0]              neg1_r;
  logic [2:0][COORD_W-1:0] st0_r, st1_r;
  logic [2:0][PW-1:0]      pr0, pr1;
  clip_t                   out_r, out_nxt;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_clip  = out_r;

  // step = floor(t * |d|), t in Q1.24
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr0[k] = PW'(in_tpar.t0) * PW'(in_tpar.geo[k].mag);
      pr1[k] = PW'(in_tpar.t1) * PW'(in_tpar.geo[k].mag);
    end
  end

  // step toward end, zero when nothing survives
  always_comb begin
    out_nxt.ok = ok1_r;
    for (int k = 0; k < 3; k++) begin
      if (!ok1_r) begin
        out_nxt.p0[k] = '0;
        out_nxt.p1[k] = '0;
      end else if (neg1_r[k]) begin
        out_nxt.p0[k] = s1_r[k] - st0_r[k];
        out_nxt.p1[k] = s1_r[k] - st1_r[k];
      end else begin
        out_nxt.p0[k] = s1_r[k] + st0_r[k];
        out_nxt.p1[k] = s1_r[k] + st1_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ok1_r <= in_tpar.ok;
      for (int k = 0; k < 3; k++) begin
        s1_r[k]   <= in_tpar.geo[k].s;
        neg1_r[k] <= in_tpar.geo[k].neg;
        st0_r[k]  <= pr0[k][T_FRAC+COORD_W-1:T_FRAC];
        st1_r[k]  <= pr1[k][T_FRAC+COORD_W-1:T_FRAC];
      end
    end
    if (rdy[1]) out_r <= out_nxt;
  end

endmodule

[verif/tb.sv]
// Testbench for segment_box_slab_clipper: random and directed segments checked against a predictor.
`timescale 1ns / 100ps
module tb;
  import scb_pkg::*;

  localparam int  HOLD_CYCLES = 300;
  localparam int  DRAIN_WAIT  = 60;
  localparam int  CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [31:0] UNIT = 32'd4096;  // 1.0 in Q20.12

  // one segment: start x,y,z then end x,y,z
  typedef logic [5:0][31:0] seg_item_t;
  // clipped segment: entry x,y,z then exit x,y,z
  typedef struct packed {
    logic             ok;
    logic [5:0][31:0] pt;
  } clip_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_wdata = '0;

  scb_seg_if  in_ch ();
  scb_clip_if out_ch ();

  segment_box_slab_clipper dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // shadow of the box registers
  logic [31:0] box_face[6];
  logic [30:0] shrink;

  seg_item_t seg_q[$];
  clip_res_t clip_q[$];
  int n_queued = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_hits = 0;
  int err_cnt = 0;
  int cyc = 0;
  int hold_cnt = 0;
  bit hold_done = 0;

  // point on the segment at t (Q1.24), product truncated toward zero
  function automatic logic [31:0] point_at(longint s, longint d, longint unsigned t);
    longint unsigned mag, step;
    longint p;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    step = (t * mag) >> T_FRAC;
    p = (d < 0) ? s - longint'(step) : s + longint'(step);
    return p[31:0];
  endfunction

  // exact slab clipping of one segment against the shrunk box
  function automatic clip_res_t clip_predict(seg_item_t it);
    clip_res_t r;
    longint lo[3], hi[3], s[3], d[3];
    longint den, a, b;
    longint unsigned en, ed, xn, xd, an, bn, dn, t0, t1;
    bit ok;
    en = 0; ed = 1; xn = 1; xd = 1;
    ok = 1;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      lo[k] = longint'($signed(box_face[2*k])) + longint'(shrink);
      hi[k] = longint'($signed(box_face[2*k+1])) - longint'(shrink);
      s[k] = longint'($signed(it[k]));
      d[k] = longint'($signed(it[k+3])) - s[k];
      if (lo[k] > hi[k]) ok = 0;
    end
    for (int k = 0; k < 3 && ok; k++) begin
      if (d[k] == 0) begin
        ok = (s[k] >= lo[k]) && (s[k] <= hi[k]);
      end else begin
        if (d[k] > 0) begin
          den = d[k]; a = lo[k] - s[k]; b = hi[k] - s[k];
        end else begin
          den = -d[k]; a = s[k] - hi[k]; b = s[k] - lo[k];
        end
        if (b < 0 || a > den) begin
          ok = 0;
        end else begin
          dn = den;
          an = (a < 0) ? 0 : a;
          bn = (b > den) ? dn : b;
          if (128'(an) * ed > 128'(en) * dn) begin en = an; ed = dn; end
          if (128'(bn) * xd < 128'(xn) * dn) begin xn = bn; xd = dn; end
          ok = (128'(en) * xd <= 128'(xn) * ed);
        end
      end
    end
    if (!ok) return r;
    t0 = (en << T_FRAC) / ed;
    t1 = (xn << T_FRAC) / xd;
    r.ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      r.pt[k]   = point_at(s[k], d[k], t0);
      r.pt[k+3] = point_at(s[k], d[k], t1);
    end
    return r;
  endfunction

  // sender: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    seg_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        clip_q.push_back(clip_predict({in_ch.end_z, in_ch.end_y, in_ch.end_x,
                                       in_ch.start_z, in_ch.start_y, in_ch.start_x}));
        n_sent++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (seg_q.size() > 0) begin
        it = seg_q.pop_front();
        {in_ch.end_z, in_ch.end_y, in_ch.end_x,
         in_ch.start_z, in_ch.start_y, in_ch.start_x} <= it;
        in_ch.valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off once the run is well underway
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (!hold_done && n_sent >= 150) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver stall pattern, changes character with bits 9:8 of cyc
  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (cyc[9:8])
        2'd0: rdy = 1'b1;
        2'd1: rdy = $urandom_range(0, 1);
        2'd2: rdy = $urandom_range(0, 3) != 0;
        default: rdy = $urandom_range(0, 3) == 0;
      endcase
      out_ch.ready <= rdy && (hold_cnt == 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    clip_res_t got, exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.ok = out_ch.clip_valid;
      got.pt = {out_ch.clip_end_z, out_ch.clip_end_y, out_ch.clip_end_x,
                out_ch.clip_start_z, out_ch.clip_start_y, out_ch.clip_start_x};
      if (clip_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: unexpected result item %p", got);
      end else begin
        exp_r = clip_q.pop_front();
        n_checked++;
        if (exp_r.ok) n_hits++;
        if (got.ok !== exp_r.ok) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: item %0d clip_valid exp %b got %b", n_checked, exp_r.ok, got.ok);
        end
        for (int k = 0; k < 6; k++) begin
          if (got.pt[k] !== exp_r.pt[k]) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("ERROR: item %0d %s%s exp %h got %h", n_checked,
                       (k < 3) ? "clip_start_" : "clip_end_",
                       (k % 3 == 0) ? "x" : (k % 3 == 1) ? "y" : "z",
                       exp_r.pt[k], got.pt[k]);
          end
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic drain();
    while (n_sent != n_queued || clip_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx == REG_MARGIN) shrink = v[30:0];
    else if (idx < REG_MARGIN) box_face[idx] = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_box(logic [31:0] x0, logic [31:0] x1, logic [31:0] y0,
                         logic [31:0] y1, logic [31:0] z0, logic [31:0] z1,
                         logic [31:0] m);
    write_reg(REG_MIN_X, x0); write_reg(REG_MAX_X, x1);
    write_reg(REG_MIN_Y, y0); write_reg(REG_MAX_Y, y1);
    write_reg(REG_MIN_Z, z0); write_reg(REG_MAX_Z, z1);
    write_reg(REG_MARGIN, m);
  endtask

  task automatic add_seg(seg_item_t it);
    seg_q.push_back(it);
    n_queued++;
  endtask

  // coordinate somewhere around the slab [lo, hi], clamped to 32 bits
  function automatic logic [31:0] near_coord(logic [31:0] lo_f, logic [31:0] hi_f);
    longint lo, hi, span, v;
    lo = $signed(lo_f);
    hi = $signed(hi_f);
    if (hi < lo) begin v = lo; lo = hi; hi = v; end
    span = hi - lo + 64 * 4096;
    case ($urandom_range(0, 7))
      0: v = lo;
      1: v = hi;
      2: v = lo - 1 + $urandom_range(0, 2);
      default: v = lo - span / 2 + longint'({$urandom, $urandom} >> 1) % (2 * span);
    endcase
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    return v[31:0];
  endfunction

  task automatic add_random(int n);
    seg_item_t it;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 6; k++)
        it[k] = (kind == 0) ? $urandom : near_coord(box_face[2*(k%3)], box_face[2*(k%3)+1]);
      // flat along one axis
      if (kind == 1 || kind == 2) begin
        int ax;
        ax = $urandom_range(0, 2);
        it[ax+3] = it[ax];
      end
      add_seg(it);
    end
  endtask

  initial begin
    longint c;
    in_ch.valid = 1'b0;
    in_ch.start_x = '0; in_ch.start_y = '0; in_ch.start_z = '0;
    in_ch.end_x = '0; in_ch.end_y = '0; in_ch.end_z = '0;
    out_ch.ready = 1'b0;
    for (int k = 0; k < 6; k++) box_face[k] = '0;
    shrink = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset box is the single point at the origin
    add_seg('0);
    add_seg({32'd0, 32'd0, 32'd4096, 32'd0, 32'd0, -32'sd4096});
    add_seg({32'd5, 32'd0, 32'd4096, 32'd5, 32'd0, -32'sd4096});
    drain();

    // directed: box of +-100 with margin 1
    c = 100 * 4096;
    set_box(-c, c, -c, c, -c, c, UNIT);
    c = 99 * 4096;
    add_seg({32'd10, 32'd20, 32'd30, -32'sd10, -32'sd20, -32'sd30});       // inside
    add_seg({32'd0, 32'd0, 32'(200 * 4096), 32'd0, 32'd0, -32'(200 * 4096)}); // crossing x
    add_seg({32'd0, 32'(200 * 4096), 32'd0, 32'd0, -32'(200 * 4096), 32'd0}); // crossing y
    add_seg({32'(200*4096), 32'd0, 32'd0, -32'(200*4096), 32'd0, 32'd0});     // crossing z
    add_seg({32'd0, 32'd0, 32'(300 * 4096), 32'd0, 32'd0, 32'(200 * 4096)}); // outside
    add_seg({32'd7, 32'd3, 32'(c), 32'd7, 32'd3, 32'(c + 4096)});           // touches face at t=1
    add_seg({32'd7, 32'd3, 32'(c + 4096), 32'd7, 32'd3, 32'(c)});           // touches at t=0
    add_seg({32'(c), 32'(c), 32'(c + 10), 32'(c + 10), 32'(c + 10), 32'(c)}); // corner point
    add_seg({32'd1, 32'(c + 1), 32'd0, 32'd9, 32'(c + 1), 32'd0});          // flat y outside
    add_seg({32'd1, 32'(c), 32'd0, 32'd9, 32'(c), 32'd0});                  // flat y on face
    add_seg({32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h80000000, 32'h80000000, 32'h80000000});                    // extremes
    add_seg({32'h80000000, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    add_seg({32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    add_seg({32'd3, -32'sd5, 32'd1, -32'sd3, 32'd5, -32'sd1});              // short odd steps
    drain();
    // ignored index leaves the box intact
    write_reg(REG_UNUSED, 32'hdeadbeef);
    add_random(8);
    drain();

    // moderate random box, small margin
    set_box(-32'sd400000, 32'sd300000, -32'sd123456, 32'sd654321,
            -32'sd9000, 32'sd9000, 32'd2000);
    add_random(90);
    drain();
    // widest box
    set_box(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h7fffffff, 32'd0);
    add_random(70);
    drain();
    // large margin that leaves a thin box
    set_box(32'h80000000, 32'h7fffffff, -32'sd1000000, 32'sd1000000,
            -32'sd600000, 32'sd600000, 32'd599990);
    add_random(60);
    drain();
    // largest margin inverts the box
    set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'h7fffffff);
    add_random(15);
    drain();
    // box inverted before shrinking
    set_box(32'sd50000, -32'sd50000, -32'sd50000, 32'sd50000, -32'sd50000, 32'sd50000, 32'd0);
    add_random(15);
    drain();
    // fully random settings, ordered faces
    for (int p = 0; p < 3; p++) begin
      logic [31:0] f[6];
      for (int k = 0; k < 6; k += 2) begin
        f[k] = $urandom;
        f[k+1] = $urandom;
        if ($signed(f[k]) > $signed(f[k+1])) {f[k], f[k+1]} = {f[k+1], f[k]};
      end
      set_box(f[0], f[1], f[2], f[3], f[4], f[5], $urandom_range(0, 1 << 20));
      add_random(50);
      drain();
    end

    $display("tb: %0d segments checked, %0d clipped hits, across 10 box settings", n_checked,
             n_hits);
    $display("tb: covered flat axes, face touches, inverted boxes and a long output stall");
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
